// ----- sv/qrm_pkg.sv -----
// Package for the quaternion to rotation matrix unit.
// Request and result payload types and fixed widths; no dependencies.
`default_nettype none
package qrm_pkg;

  // Matrix elements per request, row-major
  localparam int NUM_LANES = 9;
  // Sum of four squared Q2.14 values: up to 2^32, unsigned
  localparam int NORM_W    = 33;
  // Signed numerator width, |num| <= 2^32
  localparam int NUM_W     = 34;
  // Product of two 16-bit signed values
  localparam int PROD_W    = 32;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_error;
  } mat_t;

endpackage
`default_nettype wire

// ----- sv/qrm_if.sv -----
// Valid/ready channel interfaces for quaternion requests and matrix results.
// Depends on qrm_pkg.
`default_nettype none
interface qrm_quat_if import qrm_pkg::*; ();
  logic  valid;
  logic  ready;
  quat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qrm_mat_if import qrm_pkg::*; ();
  logic valid;
  logic ready;
  mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/qrm_front.sv -----
// Front end: products, norm and numerators, then sign/magnitude dividends.
// Three register stages; depends on qrm_pkg.
`default_nettype none
module qrm_front import qrm_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int DW        = FRAC_BITS + 34
) (
  input  wire logic                              clk,
  input  wire logic [2:0]                        en,
  input  wire quat_t                             q_i,
  output logic [NUM_LANES-1:0][DW-1:0]           rem_r,
  output logic [NORM_W-1:0]                      den_r,
  output logic [NUM_LANES-1:0]                   neg_r,
  output logic                                   zero_r
);

  // stage 1: the ten products
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww_r <= q_i.quat_w * q_i.quat_w;
      xx_r <= q_i.quat_x * q_i.quat_x;
      yy_r <= q_i.quat_y * q_i.quat_y;
      zz_r <= q_i.quat_z * q_i.quat_z;
      xy_r <= q_i.quat_x * q_i.quat_y;
      xz_r <= q_i.quat_x * q_i.quat_z;
      yz_r <= q_i.quat_y * q_i.quat_z;
      wx_r <= q_i.quat_w * q_i.quat_x;
      wy_r <= q_i.quat_w * q_i.quat_y;
      wz_r <= q_i.quat_w * q_i.quat_z;
    end
  end

  // stage 2: norm and the nine numerators
  logic signed [34:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz, n35;
  logic signed [NUM_W-1:0] num_nxt [NUM_LANES];
  logic signed [NUM_W-1:0] num_r   [NUM_LANES];
  logic [NORM_W-1:0]       n_r;

  always_comb begin
    eww = 35'(ww_r);
    exx = 35'(xx_r);
    eyy = 35'(yy_r);
    ezz = 35'(zz_r);
    exy = 35'(xy_r);
    exz = 35'(xz_r);
    eyz = 35'(yz_r);
    ewx = 35'(wx_r);
    ewy = 35'(wy_r);
    ewz = 35'(wz_r);
    n35 = eww + exx + eyy + ezz;
    num_nxt[0] = NUM_W'(n35 - ((eyy + ezz) <<< 1));
    num_nxt[1] = NUM_W'((exy - ewz) <<< 1);
    num_nxt[2] = NUM_W'((exz + ewy) <<< 1);
    num_nxt[3] = NUM_W'((exy + ewz) <<< 1);
    num_nxt[4] = NUM_W'(n35 - ((exx + ezz) <<< 1));
    num_nxt[5] = NUM_W'((eyz - ewx) <<< 1);
    num_nxt[6] = NUM_W'((exz - ewy) <<< 1);
    num_nxt[7] = NUM_W'((eyz + ewx) <<< 1);
    num_nxt[8] = NUM_W'(n35 - ((exx + eyy) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n_r <= NORM_W'(n35);
      for (int k = 0; k < NUM_LANES; k++) begin
        num_r[k] <= num_nxt[k];
      end
    end
  end

  // stage 3: magnitude scaled by 2^F plus half the divisor for rounding
  logic [NORM_W-1:0]                mag [NUM_LANES];
  logic [NUM_LANES-1:0][DW-1:0]     rem_nxt;
  logic [NUM_LANES-1:0]             neg_nxt;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      neg_nxt[k] = num_r[k][NUM_W-1];
      mag[k]     = neg_nxt[k] ? NORM_W'(-num_r[k]) : NORM_W'(num_r[k]);
      rem_nxt[k] = (DW'(mag[k]) << FRAC_BITS) + DW'(n_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_r  <= rem_nxt;
      neg_r  <= neg_nxt;
      den_r  <= n_r;
      zero_r <= (n_r == '0);
    end
  end

endmodule
`default_nettype wire

// ----- sv/qrm_div_step.sv -----
// One restoring-division step: settles one quotient bit in all nine lanes.
// Depends on qrm_pkg.
`default_nettype none
module qrm_div_step import qrm_pkg::*; #(
  parameter int DW  = 48,
  parameter int QB  = 16,
  parameter int BIT = 0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [NUM_LANES-1:0][DW-1:0]  rem_i,
  input  wire logic [NUM_LANES-1:0][QB-1:0]  q_i,
  input  wire logic [NORM_W-1:0]             den_i,
  input  wire logic [NUM_LANES-1:0]          neg_i,
  input  wire logic                          zero_i,
  output logic [NUM_LANES-1:0][DW-1:0]       rem_r,
  output logic [NUM_LANES-1:0][QB-1:0]       q_r,
  output logic [NORM_W-1:0]                  den_r,
  output logic [NUM_LANES-1:0]               neg_r,
  output logic                               zero_r
);

  logic [DW-1:0]                    trial;
  logic [NUM_LANES-1:0][DW-1:0]     rem_nxt;
  logic [NUM_LANES-1:0][QB-1:0]     q_nxt;
  logic                             ge;

  // compare against the shifted divisor and subtract when it fits
  always_comb begin
    trial = DW'(den_i) << BIT;
    ge    = 1'b0;
    for (int k = 0; k < NUM_LANES; k++) begin
      ge         = (rem_i[k] >= trial);
      rem_nxt[k] = ge ? (rem_i[k] - trial) : rem_i[k];
      q_nxt[k]   = {q_i[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      den_r  <= den_i;
      neg_r  <= neg_i;
      zero_r <= zero_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/qrm_back.sv -----
// Output stage: applies sign, saturates to 16 bits, substitutes identity.
// Depends on qrm_pkg.
`default_nettype none
module qrm_back import qrm_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int QB        = FRAC_BITS + 2
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [NUM_LANES-1:0][QB-1:0]  q_i,
  input  wire logic [NUM_LANES-1:0]          neg_i,
  input  wire logic                          zero_i,
  output mat_t                               m_r
);

  localparam int EW = QB + 17;
  localparam logic [15:0] ONE = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

  logic [NUM_LANES-1:0][15:0] el;
  logic [EW-1:0]              qe;
  mat_t                       m_nxt;

  // signed saturation of each quotient, or the identity for a zero quaternion
  always_comb begin
    qe = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      qe = EW'(q_i[k]);
      if (!neg_i[k]) begin
        el[k] = (qe > EW'(32767)) ? 16'h7fff : 16'(qe);
      end else begin
        el[k] = (qe > EW'(32768)) ? 16'h8000 : 16'(-qe);
      end
    end
    if (zero_i) begin
      m_nxt = '{m00: ONE, m01: '0, m02: '0, m10: '0, m11: ONE, m12: '0,
                m20: '0, m21: '0, m22: ONE, zero_error: 1'b1};
    end else begin
      m_nxt = '{m00: el[0], m01: el[1], m02: el[2], m10: el[3], m11: el[4],
                m12: el[5], m20: el[6], m21: el[7], m22: el[8], zero_error: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/quaternion_to_rotation_matrix_unit.sv -----
// Quaternion to rotation matrix unit.
// Channels: in_q carries one quaternion (w, x, y, z), signed Q2.FRAC_BITS, per
// request; out_m returns the nine matrix elements, row-major, saturated to
// 16 bits, plus zero_error. A zero quaternion gives the identity with
// zero_error set. Both channels move a request when valid and ready are high.
// Pipeline: 3 front stages (products, norm/numerators, dividends), one
// restoring-division stage per quotient bit (FRAC_BITS + 2 of them), and
// the output register.
// Throughput: one request per cycle unless an out_m stall fills the stages;
// the division chain of compare/subtract stages, one bit each, sets the depth.
// Each stage carries its own valid bit and loads when it is empty or the
// stage after it moves, so bubbles close up and in_q stays ready while a
// result waits on out_m if any stage is empty. A stall of out_m holds the
// result in place and fills the stages behind it; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// not reset.
// Depends on qrm_pkg, qrm_if, qrm_front, qrm_div_step, qrm_back.
`default_nettype none
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qrm_quat_if.sink    in_q,
  qrm_mat_if.source   out_m
);

  localparam int QB = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 34;
  localparam int NS = QB + 4;

  // per-stage valid bits and load enables
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_m.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_q.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_q.ready  = rdy[0];
  assign out_m.valid = vld_r[NS-1];

  // datapath
  logic [QB:0][NUM_LANES-1:0][DW-1:0] rem_c;
  logic [QB:0][NUM_LANES-1:0][QB-1:0] q_c;
  logic [QB:0][NORM_W-1:0]            den_c;
  logic [QB:0][NUM_LANES-1:0]         neg_c;
  logic [QB:0]                        zero_c;

  assign q_c[0] = '0;

  qrm_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk    (clk),
    .en     (rdy[2:0]),
    .q_i    (in_q.data),
    .rem_r  (rem_c[0]),
    .den_r  (den_c[0]),
    .neg_r  (neg_c[0]),
    .zero_r (zero_c[0])
  );

  for (genvar s = 0; s < QB; s++) begin : g_div
    qrm_div_step #(.DW(DW), .QB(QB), .BIT(QB - 1 - s)) u_step (
      .clk    (clk),
      .en     (rdy[3+s]),
      .rem_i  (rem_c[s]),
      .q_i    (q_c[s]),
      .den_i  (den_c[s]),
      .neg_i  (neg_c[s]),
      .zero_i (zero_c[s]),
      .rem_r  (rem_c[s+1]),
      .q_r    (q_c[s+1]),
      .den_r  (den_c[s+1]),
      .neg_r  (neg_c[s+1]),
      .zero_r (zero_c[s+1])
    );
  end

  qrm_back #(.FRAC_BITS(FRAC_BITS), .QB(QB)) u_back (
    .clk    (clk),
    .en     (rdy[NS-1]),
    .q_i    (q_c[QB]),
    .neg_i  (neg_c[QB]),
    .zero_i (zero_c[QB]),
    .m_r    (out_m.data)
  );

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_m.valid)
    else $error("result valid after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_q.valid && in_q.ready |=> vld_r[0])
    else $error("accepted request not captured in first stage");

  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.data.zero_error |->
      out_m.data.m01 == 16'sd0 && out_m.data.m10 == 16'sd0 && out_m.data.m22 != 16'sd0)
    else $error("zero quaternion did not give identity");

endmodule
`default_nettype wire

// ----- bench/quaternion_to_rotation_matrix_unit_test.sv -----
// Self-checking bench for the quaternion to rotation matrix unit.
// Drives quaternion requests, predicts each matrix, compares in order.
// Depends on qrm_pkg, qrm_if and the unit's RTL.
`default_nettype none
module quaternion_to_rotation_matrix_unit_test;
  import qrm_pkg::*;

  localparam int FRAC_BITS   = 14;
  localparam int LATENCY     = FRAC_BITS + 6;
  localparam int NUM_RANDOM  = 1880;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;

  qrm_quat_if quat_ch ();
  qrm_mat_if  mat_ch ();

  quaternion_to_rotation_matrix_unit #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_q  (quat_ch.sink),
    .out_m (mat_ch.source)
  );

  // Directed stimulus row; known matrix given where it is obvious
  typedef struct {
    quat_t q;
    bit    has_known;
    mat_t  known;
  } quat_row_t;

  mat_t expected_mats[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   sent_count = 0;
  int   matrix_count = 0;
  int   zero_count = 0;
  bit   sending_done;
  bit   hold_off;
  bit   idle_free;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounded, saturated ratio num * 2^F / den, ties away from zero
  function automatic logic signed [15:0] scaled_ratio(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< FRAC_BITS) + den / 2) / den;
    if (q > 65536) q = 65536;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint w, x, y, z, n;
    mat_t m;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    n = w*w + x*x + y*y + z*z;
    m = '0;
    if (n == 0) begin
      m.m00 = (FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << FRAC_BITS);
      m.m11 = m.m00;
      m.m22 = m.m00;
      m.zero_error = 1'b1;
    end else begin
      m.m00 = scaled_ratio(n - 2*(y*y + z*z), n);
      m.m01 = scaled_ratio(2*(x*y - w*z), n);
      m.m02 = scaled_ratio(2*(x*z + w*y), n);
      m.m10 = scaled_ratio(2*(x*y + w*z), n);
      m.m11 = scaled_ratio(n - 2*(x*x + z*z), n);
      m.m12 = scaled_ratio(2*(y*z - w*x), n);
      m.m20 = scaled_ratio(2*(x*z - w*y), n);
      m.m21 = scaled_ratio(2*(y*z + w*x), n);
      m.m22 = scaled_ratio(n - 2*(x*x + y*y), n);
    end
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", matrix_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
    return q;
  endfunction

  // Random quaternion: components within +/-1.0, full-range noise, tiny values or one axis
  function automatic quat_t random_quat();
    int kind;
    quat_t q;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      q = make_quat($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                    $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
    end else if (kind < 8) begin
      q = quat_t'({$urandom(), $urandom()});
    end else if (kind == 8) begin
      q = make_quat($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                    $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
    end else begin
      q = '0;
      case ($urandom_range(0, 3))
        0: q.quat_w = $urandom();
        1: q.quat_x = $urandom();
        2: q.quat_y = $urandom();
        default: q.quat_z = $urandom();
      endcase
    end
    return q;
  endfunction

  // Offer one request, after random idling unless idle_free is set, then wait for it to be taken
  task automatic send_request(quat_t q);
    while (!idle_free && $urandom_range(0, 99) < 33) begin
      quat_ch.valid <= 1'b0;
      @(posedge clk);
    end
    quat_ch.valid <= 1'b1;
    quat_ch.data  <= q;
    @(posedge clk);
    while (!quat_ch.ready) @(posedge clk);
    expected_mats.push_back(rotation_of(q));
    if (q == '0) zero_count++;
    sent_count++;
  endtask

  // Request side
  initial begin
    quat_row_t rows[$];
    quat_row_t r;
    mat_t ident;
    int i;
    quat_ch.valid = 1'b0;
    quat_ch.data  = '0;
    rst_n = 1'b0;
    sending_done = 1'b0;
    idle_free = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    ident = '0;
    ident.m00 = 16'sd16384; ident.m11 = 16'sd16384; ident.m22 = 16'sd16384;
    ident.zero_error = 1'b1;
    r.has_known = 1'b1; r.q = '0; r.known = ident; rows.push_back(r);
    // Identity rotation from a positive unit w
    r.q = make_quat(16384, 0, 0, 0); r.known = ident; r.known.zero_error = 1'b0;
    rows.push_back(r);
    // 180 degrees about x: diag (1,-1,-1)
    r.q = make_quat(0, 16384, 0, 0); r.known = '0;
    r.known.m00 = 16'sd16384; r.known.m11 = -16'sd16384; r.known.m22 = -16'sd16384;
    rows.push_back(r);
    r.has_known = 1'b0;
    r.q = make_quat(-32768, -32768, -32768, -32768); rows.push_back(r);
    r.q = make_quat(32767, 32767, 32767, 32767);     rows.push_back(r);
    r.q = make_quat(-32768, 32767, -32768, 32767);   rows.push_back(r);
    r.q = make_quat(0, 0, 0, 1);                     rows.push_back(r);
    r.q = make_quat(0, 0, 0, -32768);                rows.push_back(r);
    r.q = make_quat(0, 0, 32767, 0);                 rows.push_back(r);
    r.q = make_quat(1, 1, 0, 0);                     rows.push_back(r);
    r.q = make_quat(1, 1, 1, 1);                     rows.push_back(r);
    r.q = make_quat(11585, 11585, 0, 0);             rows.push_back(r);
    r.q = make_quat(-11585, 0, 11585, 0);            rows.push_back(r);
    r.q = make_quat(3, -1, 2, -2);                   rows.push_back(r);
    r.q = make_quat(-1, 0, 0, 0);                    rows.push_back(r);
    r.q = make_quat(21845, -21846, 10922, -5461);    rows.push_back(r);

    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].has_known && rotation_of(rows[i].q) != rows[i].known)
        report_mismatch("directed row prediction", i, 0);
      send_request(rows[i].q);
    end
    for (i = 0; i < NUM_RANDOM; i++) begin
      // a stretch with no idling in the middle
      idle_free = (i >= 800 && i < 1100);
      send_request(random_quat());
    end
    quat_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side ready, with one long hold-off while requests keep coming
  initial begin
    int held;
    hold_off = 1'b0;
    mat_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (sent_count == 300 && !hold_off) begin
        hold_off = 1'b1;
        mat_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      if (!idle_free && $urandom_range(0, 99) < 33) mat_ch.ready <= 1'b0;
      else mat_ch.ready <= 1'b1;
    end
  end

  // Compare accepted results against the oldest prediction
  always @(posedge clk) begin
    mat_t got;
    mat_t want;
    if (rst_n && mat_ch.valid && mat_ch.ready) begin
      got = mat_ch.data;
      if (expected_mats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_mats.pop_front();
        if (got.m00 != want.m00) report_mismatch("m00", got.m00, want.m00);
        if (got.m01 != want.m01) report_mismatch("m01", got.m01, want.m01);
        if (got.m02 != want.m02) report_mismatch("m02", got.m02, want.m02);
        if (got.m10 != want.m10) report_mismatch("m10", got.m10, want.m10);
        if (got.m11 != want.m11) report_mismatch("m11", got.m11, want.m11);
        if (got.m12 != want.m12) report_mismatch("m12", got.m12, want.m12);
        if (got.m20 != want.m20) report_mismatch("m20", got.m20, want.m20);
        if (got.m21 != want.m21) report_mismatch("m21", got.m21, want.m21);
        if (got.m22 != want.m22) report_mismatch("m22", got.m22, want.m22);
        if (got.zero_error != want.zero_error)
          report_mismatch("zero_error", got.zero_error, want.zero_error);
      end
      matrix_count++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Drain, then verdict
  initial begin
    wait (sending_done);
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (expected_mats.size() != 0) report_mismatch("results left over", expected_mats.size(), 0);
    $display("Covered %0d quaternion requests (%0d zero) and %0d matrices, with a long output stall",
             sent_count, zero_count, matrix_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/qrm_pkg.sv
sv/qrm_if.sv
sv/qrm_front.sv
sv/qrm_div_step.sv
sv/qrm_back.sv
sv/quaternion_to_rotation_matrix_unit.sv
bench/quaternion_to_rotation_matrix_unit_test.sv
